FILE: design/ataci_pkg.sv
// ----------------------------------------------------------------------------
// ataci_pkg
// Shared types, codes and command tables for the ATA command issue block.
// ----------------------------------------------------------------------------
package ataci_pkg;

    localparam int NUM_WRITES = 13;
    localparam int STEP_W     = 4;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_WRITES - 1);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_DEVICE = 2'd1;
    localparam logic [1:0] ST_UNKNOWN   = 2'd2;
    localparam logic [1:0] ST_NOT_READY = 2'd3;

    localparam logic [2:0] RA_CONTROL  = 3'd0;
    localparam logic [2:0] RA_FEATURE  = 3'd1;
    localparam logic [2:0] RA_COUNT    = 3'd2;
    localparam logic [2:0] RA_SECTOR   = 3'd3;
    localparam logic [2:0] RA_CYL_LOW  = 3'd4;
    localparam logic [2:0] RA_CYL_HIGH = 3'd5;
    localparam logic [2:0] RA_SELECT   = 3'd6;
    localparam logic [2:0] RA_COMMAND  = 3'd7;

    localparam logic [1:0] TMO_NONE   = 2'd0;
    localparam logic [1:0] TMO_NORMAL = 2'd1;
    localparam logic [1:0] TMO_LONG   = 2'd2;

    localparam logic [3:0] CLS_NONE    = 4'd0;
    localparam logic [3:0] CLS_NONDATA = 4'd1;
    localparam logic [3:0] CLS_DMA     = 4'd4;
    localparam logic [3:0] CLS_DIAG    = 4'd6;

    localparam logic [7:0] OP_SEC_CONTROL = 8'h8E;
    localparam logic [7:0] OP_SMART       = 8'hB0;
    localparam logic [7:0] OP_SEC_ERASE   = 8'hF4;
    localparam logic [7:0] OP_READ_DMA    = 8'hC8;
    localparam logic [7:0] OP_READ_DMA48  = 8'h25;

    localparam logic [7:0] CTRL_NO_IRQ = 8'h02;
    localparam logic [7:0] CTRL_IRQ    = 8'h00;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  cls;
        logic [1:0]  tmo;
        logic        irq;
        logic        dma;
        logic [15:0] feat;
        logic [15:0] cnt;
        logic [15:0] sec;
        logic [15:0] cyl_low;
        logic [15:0] cyl_high;
        logic [7:0]  sel;
        logic [7:0]  op;
    } desc_t;

    function automatic logic [3:0] main_class(input logic [7:0] op);
        logic [3:0] k;
        case (op)
            8'h00, 8'h03, 8'h40, 8'h70, 8'h91, 8'hc0, 8'hc6, 8'hda, 8'hde,
            8'hdf, 8'he0, 8'he1, 8'he2, 8'he3, 8'he5, 8'he6, 8'he7, 8'hed,
            8'hef, 8'hf3, 8'hf5, 8'hf8, 8'hf9, 8'hea:          k = 4'd1;
            8'h20, 8'h87, 8'ha1, 8'hc4, 8'he4, 8'hec:          k = 4'd2;
            8'h30, 8'h38, 8'h92, 8'hc5, 8'hcd, 8'he8, 8'hf1,
            8'hf2, 8'hf4, 8'hf6:                               k = 4'd3;
            8'hc8, 8'hca, 8'h25, 8'h35:                        k = 4'd4;
            8'h08:                                             k = 4'd5;
            8'h90:                                             k = 4'd6;
            8'h8e, 8'hb0:                                      k = 4'd7;
            8'h32:                                             k = 4'd8;
            default:                                           k = CLS_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] sec_class(input logic [7:0] sub);
        logic [3:0] k;
        case (sub)
            8'hf3, 8'hf4, 8'hf5: k = 4'd1;
            8'hec, 8'h20:        k = 4'd2;
            8'hf1, 8'hf2, 8'h30: k = 4'd3;
            default:             k = CLS_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] smart_class(input logic [7:0] sub);
        logic [3:0] k;
        case (sub)
            8'hd2, 8'hd3, 8'hd4, 8'hd8, 8'hd9, 8'hda: k = 4'd1;
            8'hd0, 8'hd5:                             k = 4'd2;
            8'hd6:                                    k = 4'd3;
            default:                                  k = CLS_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] step_addr(input logic [STEP_W-1:0] step);
        logic [2:0] a;
        case (step)
            4'd0:        a = RA_CONTROL;
            4'd1, 4'd6:  a = RA_FEATURE;
            4'd2, 4'd7:  a = RA_COUNT;
            4'd3, 4'd8:  a = RA_SECTOR;
            4'd4, 4'd9:  a = RA_CYL_LOW;
            4'd5, 4'd10: a = RA_CYL_HIGH;
            4'd11:       a = RA_SELECT;
            default:     a = RA_COMMAND;
        endcase
        return a;
    endfunction

endpackage

FILE: design/ataci_front.sv
// ----------------------------------------------------------------------------
// ataci_front
// Request intake: device check, command classification, readiness check,
// timeout and DMA direction choice; writes one descriptor per request.
// ----------------------------------------------------------------------------
module ataci_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_data,
    input  logic                 push,
    input  logic                 q_full,
    output logic                 q_push,
    output ataci_pkg::desc_t     q_desc,
    input  logic [15:0]          feature_word,
    input  logic [15:0]          count_word,
    input  logic [15:0]          sector_word,
    input  logic [15:0]          cyl_low_word,
    input  logic [15:0]          cyl_high_word,
    input  logic [7:0]           select_byte,
    input  logic [7:0]           opcode,
    input  logic                 drive_ready
);

    logic [1:0] present_mask_reg;
    logic       dma_dir_reg;
    logic       dma_dir_next;
    logic [3:0] kind;
    logic       exempt;
    logic       timed;
    logic       long_erase;
    logic [1:0] st;

    assign cfg_ready = 1'b1;
    assign q_push    = push && !q_full;

    always_comb
    begin
        if (opcode == ataci_pkg::OP_SEC_CONTROL)
        begin
            kind = ataci_pkg::sec_class(feature_word[7:0]);
        end
        else if (opcode == ataci_pkg::OP_SMART)
        begin
            kind = ataci_pkg::smart_class(feature_word[7:0]);
        end
        else
        begin
            kind = ataci_pkg::main_class(opcode);
        end
    end

    assign exempt = opcode inside {8'h08, 8'h90, 8'h91, 8'hA0, 8'hA1};
    assign timed  = kind inside {ataci_pkg::CLS_NONDATA, ataci_pkg::CLS_DMA,
                                 ataci_pkg::CLS_DIAG};
    assign long_erase = (opcode == ataci_pkg::OP_SEC_ERASE) ||
                        ((opcode == ataci_pkg::OP_SEC_CONTROL) &&
                         (feature_word == {8'h00, ataci_pkg::OP_SEC_ERASE}));

    always_comb
    begin
        if (!present_mask_reg[select_byte[4]])
        begin
            st = ataci_pkg::ST_NO_DEVICE;
        end
        else if (kind == ataci_pkg::CLS_NONE)
        begin
            st = ataci_pkg::ST_UNKNOWN;
        end
        else if (!drive_ready && !exempt)
        begin
            st = ataci_pkg::ST_NOT_READY;
        end
        else
        begin
            st = ataci_pkg::ST_OK;
        end
    end

    assign dma_dir_next = (kind == ataci_pkg::CLS_DMA) ?
                          ((opcode != ataci_pkg::OP_READ_DMA) &&
                           (opcode != ataci_pkg::OP_READ_DMA48)) : dma_dir_reg;

    always_comb
    begin
        q_desc          = '0;
        q_desc.status   = st;
        q_desc.feat     = feature_word;
        q_desc.cnt      = count_word;
        q_desc.sec      = sector_word;
        q_desc.cyl_low  = cyl_low_word;
        q_desc.cyl_high = cyl_high_word;
        q_desc.sel      = select_byte;
        q_desc.op       = opcode;
        if (st == ataci_pkg::ST_OK || st == ataci_pkg::ST_NOT_READY)
        begin
            q_desc.cls = kind;
        end
        if (st == ataci_pkg::ST_OK)
        begin
            q_desc.irq = (kind == ataci_pkg::CLS_NONDATA);
            q_desc.dma = (kind == ataci_pkg::CLS_DMA) && dma_dir_next;
            if (timed)
            begin
                q_desc.tmo = long_erase ? ataci_pkg::TMO_LONG : ataci_pkg::TMO_NORMAL;
            end
            else
            begin
                q_desc.tmo = ataci_pkg::TMO_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_mask_reg <= '0;
            dma_dir_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                present_mask_reg <= cfg_data;
            end
            if (q_push && st == ataci_pkg::ST_OK)
            begin
                dma_dir_reg <= dma_dir_next;
            end
        end
    end

endmodule

FILE: design/ataci_queue.sv
// ----------------------------------------------------------------------------
// ataci_queue
// Two-entry descriptor queue between intake and register sequencer.
// ----------------------------------------------------------------------------
module ataci_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  ataci_pkg::desc_t wr_desc,
    output logic             full,
    input  logic             rd_en,
    output ataci_pkg::desc_t rd_desc,
    output logic             empty
);

    ataci_pkg::desc_t                 mem_reg [ataci_pkg::QDEPTH];
    logic [ataci_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [ataci_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [ataci_pkg::QCNT_W-1:0]     count_reg;
    logic [ataci_pkg::QCNT_W-1:0]     count_next;

    assign full    = (count_reg == ataci_pkg::QCNT_W'(ataci_pkg::QDEPTH));
    assign empty   = (count_reg == '0);
    assign rd_desc = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: design/ataci_back.sv
// ----------------------------------------------------------------------------
// ataci_back
// Register sequencer: expands a descriptor into the taskfile write
// sequence (or one error result) into a registered result stage.
// ----------------------------------------------------------------------------
module ataci_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  ataci_pkg::desc_t     q_desc,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           status,
    output logic [2:0]           reg_addr,
    output logic [7:0]           reg_data,
    output logic [3:0]           cmd_class,
    output logic [1:0]           timeout_mode,
    output logic                 enable_done_irq,
    output logic                 dma_from_memory,
    output logic                 last
);

    logic [ataci_pkg::STEP_W-1:0] step_reg;
    logic                         out_valid_reg;
    logic [1:0]                   status_reg;
    logic [2:0]                   addr_reg;
    logic [7:0]                   data_reg;
    logic [3:0]                   cls_reg;
    logic [1:0]                   tmo_reg;
    logic                         irq_reg;
    logic                         dma_reg;
    logic                         last_reg;
    logic                         load;
    logic                         is_err;
    logic                         res_last;
    logic [7:0]                   res_data;

    assign load     = !q_empty && (!out_valid_reg || pop);
    assign is_err   = (q_desc.status != ataci_pkg::ST_OK);
    assign res_last = is_err || (step_reg == ataci_pkg::STEP_LAST);
    assign q_pop    = load && res_last;

    always_comb
    begin
        case (step_reg)
            4'd0:    res_data = (q_desc.tmo == ataci_pkg::TMO_NONE) ?
                                ataci_pkg::CTRL_NO_IRQ : ataci_pkg::CTRL_IRQ;
            4'd1:    res_data = q_desc.feat[15:8];
            4'd2:    res_data = q_desc.cnt[15:8];
            4'd3:    res_data = q_desc.sec[15:8];
            4'd4:    res_data = q_desc.cyl_low[15:8];
            4'd5:    res_data = q_desc.cyl_high[15:8];
            4'd6:    res_data = q_desc.feat[7:0];
            4'd7:    res_data = q_desc.cnt[7:0];
            4'd8:    res_data = q_desc.sec[7:0];
            4'd9:    res_data = q_desc.cyl_low[7:0];
            4'd10:   res_data = q_desc.cyl_high[7:0];
            4'd11:   res_data = q_desc.sel;
            default: res_data = q_desc.op;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= q_desc.status;
            cls_reg    <= q_desc.cls;
            tmo_reg    <= q_desc.tmo;
            irq_reg    <= q_desc.irq;
            dma_reg    <= q_desc.dma;
            last_reg   <= res_last;
            addr_reg   <= is_err ? ataci_pkg::RA_CONTROL : ataci_pkg::step_addr(step_reg);
            data_reg   <= is_err ? 8'h00 : res_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                step_reg      <= res_last ? '0 : step_reg + 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty           = !out_valid_reg;
    assign status          = status_reg;
    assign reg_addr        = addr_reg;
    assign reg_data        = data_reg;
    assign cmd_class       = cls_reg;
    assign timeout_mode    = tmo_reg;
    assign enable_done_irq = irq_reg;
    assign dma_from_memory = dma_reg;
    assign last            = last_reg;

endmodule

FILE: design/ata_command_issue_top.sv
// ----------------------------------------------------------------------------
// ata_command_issue_top
// ATA command issue: validates a command request and emits its taskfile
// register writes (48-bit style, high byte then low byte).
//
// Usage:
//   Config: write device_present_mask on cfg_data with cfg_valid; cfg_ready is
//   always high. Write it only while no request is in flight.
//   Input: a request transaction is taken when push is high and full is low.
//   Output: while empty is low the oldest result is on the result ports; pop
//   takes it. A good request gives 13 writes (control, high bytes, low bytes,
//   select, command), last set on the command write. A failed check gives one
//   result with nonzero status and last set.
//   Path: a request passes the descriptor queue, then the result register.
//   Throughput: one result per cycle while pop is high; a good request holds
//   the sequencer for all its writes and an error request for its one result;
//   a two-entry descriptor queue lets intake run ahead of the sequencer.
//   Stall: with pop low the result register holds; a descriptor stays queued
//   until its last write is loaded, and full rises once two are queued.
//   Reset: queue and result stage emptied, device mask and DMA direction
//   cleared.
// ----------------------------------------------------------------------------
module ata_command_issue_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [15:0] feature_word,
    input  logic [15:0] count_word,
    input  logic [15:0] sector_word,
    input  logic [15:0] cyl_low_word,
    input  logic [15:0] cyl_high_word,
    input  logic [7:0]  select_byte,
    input  logic [7:0]  opcode,
    input  logic [15:0] block_count,
    input  logic        drive_ready,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [2:0]  reg_addr,
    output logic [7:0]  reg_data,
    output logic [3:0]  cmd_class,
    output logic [1:0]  timeout_mode,
    output logic        enable_done_irq,
    output logic        dma_from_memory,
    output logic        last
);

    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    ataci_pkg::desc_t wr_desc;
    ataci_pkg::desc_t rd_desc;
    logic [15:0]      pending_blocks_reg;

    assign full = q_full;

    // block count of the last classified transaction, kept as status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_blocks_reg <= '0;
        end
        else if (q_push && wr_desc.cls != ataci_pkg::CLS_NONE)
        begin
            pending_blocks_reg <= block_count;
        end
    end

    ataci_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .push          (push),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_desc        (wr_desc),
        .feature_word  (feature_word),
        .count_word    (count_word),
        .sector_word   (sector_word),
        .cyl_low_word  (cyl_low_word),
        .cyl_high_word (cyl_high_word),
        .select_byte   (select_byte),
        .opcode        (opcode),
        .drive_ready   (drive_ready)
    );

    ataci_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_desc (wr_desc),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_desc (rd_desc),
        .empty   (q_empty)
    );

    ataci_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_desc          (rd_desc),
        .q_pop           (q_pop),
        .empty           (empty),
        .pop             (pop),
        .status          (status),
        .reg_addr        (reg_addr),
        .reg_data        (reg_data),
        .cmd_class       (cmd_class),
        .timeout_mode    (timeout_mode),
        .enable_done_irq (enable_done_irq),
        .dma_from_memory (dma_from_memory),
        .last            (last)
    );

`ifndef SYNTHESIS
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ataci_pkg::ST_OK) |->
            (last && reg_addr == ataci_pkg::RA_CONTROL && reg_data == 8'h00))
        else $error("error result not a single cleared write");

    a_last_on_command: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ataci_pkg::ST_OK) |->
            (last == (reg_addr == ataci_pkg::RA_COMMAND)))
        else $error("last not aligned with command write");

    a_no_class_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == ataci_pkg::ST_NO_DEVICE ||
                    status == ataci_pkg::ST_UNKNOWN)) |->
            (cmd_class == ataci_pkg::CLS_NONE))
        else $error("class reported on failed lookup");

    a_seq_order: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last && status == ataci_pkg::ST_OK) |=>
            (!empty && (reg_addr != ataci_pkg::RA_CONTROL)))
        else $error("write sequence broken or restarted early");

    a_status_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && wr_desc.cls != ataci_pkg::CLS_NONE) |=>
            (pending_blocks_reg == $past(block_count)))
        else $error("pending block count not captured");
`endif

endmodule
